// File: rtl/kwts_pkg.sv
package kwts_pkg;

  // field widths
  localparam int IDX_W  = 12;
  localparam int TAP_W  = 24;
  localparam int LEN_W  = 13;
  localparam int BETA_W = 16;
  localparam int OFS_W  = 20;
  localparam int CFG_W  = 20;
  localparam int CIDX_W = 2;

  // block constants
  localparam int MAX_TAPS     = 4096;
  localparam int SERIES_TERMS = 64;
  localparam int BETA_MAX     = 40960;
  localparam int TERM_W       = $clog2(SERIES_TERMS + 1);

  // reset values of the registers
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4096);
  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(18432);
  localparam logic [OFS_W-1:0]  OFS_RESET  = '0;

  // datapath sizing
  localparam int Q_W            = 31;             // Q30 values up to 1.0
  localparam int DIV_W          = 33;             // long divider remainder
  localparam int DIV_STEPS      = 30;
  localparam int SQ_W           = 62;
  localparam int SQRT_STEPS     = 31;
  localparam int HALF_W         = 21;
  localparam int SER_W          = 48;             // series term
  localparam int DIGIT_W        = 8;              // bits per divide-by-k step
  localparam int SER_DIV_STEPS  = SER_W / DIGIT_W;
  localparam int SUM_W          = 57;             // series sum
  localparam int NORM_STEPS     = SUM_W - 32;
  localparam int STEP_W         = 5;
  localparam int POS_W          = 26;

  localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(1) << 30;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LENGTH = 2'd0,
    CFG_BETA   = 2'd1,
    CFG_OFFSET = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_POS,
    OP_DIV,
    OP_X2,
    OP_SQRT,
    OP_HALF,
    OP_SER_INIT_DEN,
    OP_SER_INIT_NUM,
    OP_SER_MUL,
    OP_SER_DIV,
    OP_SER_ACC,
    OP_SER_SAVE_DEN,
    OP_SER_SAVE_NUM,
    OP_NORM,
    OP_WINIT,
    OP_PRODUCT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [TERM_W-1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic beyond;
  } dp_status_t;

  typedef struct packed {
    logic [IDX_W-1:0]        tap_index;
    logic signed [TAP_W-1:0] tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [TAP_W-1:0] shaped_tap;
    logic [IDX_W-1:0]        index_echo;
    logic                    beyond_length;
  } out_item_t;

endpackage

// File: rtl/kwts_stream_if.sv
interface kwts_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/kwts_ctrl.sv
module kwts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  kwts_pkg::dp_status_t status_i,
  output kwts_pkg::dp_cmd_t    cmd_o
);
  import kwts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_PDIV, S_X2, S_SQRT, S_HALF, S_SINIT, S_SMUL,
    S_SDIV, S_SACC, S_SSAVE, S_NORM, S_WINIT, S_WDIV, S_PROD, S_OUT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [TERM_W-1:0] term_q;
  logic              sel_q;        // 0: denominator series, 1: numerator series
  logic              out_valid_q;
  logic              out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // result valid: set when a result is issued, cleared once taken
  assign out_valid_d = (state_q == S_OUT && out_free) ? 1'b1
                                                      : (out_valid_q && !out_ready_i);

  // command decode
  always_comb begin
    cmd_o.term = term_q;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_CHECK: cmd_o.op = status_i.beyond ? OP_NONE : OP_POS;
      S_PDIV:  cmd_o.op = OP_DIV;
      S_X2:    cmd_o.op = OP_X2;
      S_SQRT:  cmd_o.op = OP_SQRT;
      S_HALF:  cmd_o.op = OP_HALF;
      S_SINIT: cmd_o.op = sel_q ? OP_SER_INIT_NUM : OP_SER_INIT_DEN;
      S_SMUL:  cmd_o.op = OP_SER_MUL;
      S_SDIV:  cmd_o.op = OP_SER_DIV;
      S_SACC:  cmd_o.op = OP_SER_ACC;
      S_SSAVE: cmd_o.op = sel_q ? OP_SER_SAVE_NUM : OP_SER_SAVE_DEN;
      S_NORM:  cmd_o.op = OP_NORM;
      S_WINIT: cmd_o.op = OP_WINIT;
      S_WDIV:  cmd_o.op = OP_DIV;
      S_PROD:  cmd_o.op = OP_PRODUCT;
      S_OUT:   cmd_o.op = out_free ? OP_OUT : OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      term_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          step_q  <= '0;
          state_q <= status_i.beyond ? S_OUT : S_PDIV;
        end
        S_PDIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= S_X2;
          end
        end
        S_X2: state_q <= S_SQRT;
        S_SQRT: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SQRT_STEPS - 1)) state_q <= S_HALF;
        end
        S_HALF: begin
          sel_q   <= 1'b0;
          state_q <= S_SINIT;
        end
        S_SINIT: begin
          term_q  <= TERM_W'(1);
          state_q <= S_SMUL;
        end
        S_SMUL: begin
          step_q  <= '0;
          state_q <= S_SDIV;
        end
        S_SDIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(SER_DIV_STEPS - 1)) state_q <= S_SACC;
        end
        S_SACC: begin
          if (term_q == TERM_W'(SERIES_TERMS)) begin
            state_q <= S_SSAVE;
          end else begin
            term_q  <= term_q + TERM_W'(1);
            state_q <= S_SMUL;
          end
        end
        S_SSAVE: begin
          step_q <= '0;
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= S_SINIT;
          end else begin
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(NORM_STEPS - 1)) state_q <= S_WINIT;
        end
        S_WINIT: begin
          step_q  <= '0;
          state_q <= S_WDIV;
        end
        S_WDIV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) state_q <= S_PROD;
        end
        S_PROD: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted request did not start processing");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output state");

  a_series_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SACC && term_q == TERM_W'(SERIES_TERMS)) |=> (state_q == S_SSAVE))
    else $error("series ran past its last term");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SMUL) |-> (term_q != '0 && term_q <= TERM_W'(SERIES_TERMS)))
    else $error("series term out of range");
`endif

endmodule

// File: rtl/kwts_dp.sv
module kwts_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kwts_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [kwts_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  kwts_pkg::in_item_t             item_i,
  input  kwts_pkg::dp_cmd_t              cmd_i,
  output kwts_pkg::dp_status_t           status_o,
  output kwts_pkg::out_item_t            result_o
);
  import kwts_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]  cfg_len_q;
  logic [BETA_W-1:0] cfg_beta_q;
  logic [OFS_W-1:0]  cfg_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q  <= LEN_RESET;
      cfg_beta_q <= BETA_RESET;
      cfg_ofs_q  <= OFS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_LENGTH: cfg_len_q  <= cfg_wdata_i[LEN_W-1:0];
        CFG_BETA:   cfg_beta_q <= cfg_wdata_i[BETA_W-1:0];
        CFG_OFFSET: cfg_ofs_q  <= cfg_wdata_i[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  logic [IDX_W-1:0]        idx_q;
  logic signed [TAP_W-1:0] tap_q;
  logic                    beyond_q;
  logic [DIV_W-1:0]        div_rem_q, div_d_q;
  logic [DIV_STEPS-1:0]    div_q_q;
  logic                    div_sat_q;
  logic [SQ_W-2:0]         sq_v_q, sq_bit_q;
  logic [SQ_W-1:0]         sq_res_q;
  logic [HALF_W-1:0]       half_num_q, ser_half_q;
  logic [SER_W-1:0]        ser_a_q;
  logic [DIGIT_W-1:0]      ser_r_q;
  logic [SUM_W-1:0]        ser_sum_q, den_sum_q, num_sum_q;
  logic signed [TAP_W-1:0] res_q;
  out_item_t               result_q;

  // clamped settings
  logic [LEN_W-1:0]  len_c;
  logic [BETA_W-1:0] beta_c;
  assign len_c  = (32'(cfg_len_q) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : cfg_len_q;
  assign beta_c = (32'(cfg_beta_q) > BETA_MAX) ? BETA_W'(BETA_MAX) : cfg_beta_q;

  // divider quotient as Q30
  logic [Q_W-1:0] div_val;
  assign div_val = div_sat_q ? ONE_Q30 : {1'b0, div_q_q};

  // tap position numerator and denominator
  logic signed [POS_W-1:0] pi, pl, pfl, pfr, pmx, pmaxl, pdl, pd0, pn, pd;
  always_comb begin
    pi    = $signed({{(POS_W-IDX_W){1'b0}}, idx_q});
    pl    = $signed({{(POS_W-LEN_W){1'b0}}, len_c});
    pfl   = $signed({{(POS_W-12){cfg_ofs_q[OFS_W-1]}}, cfg_ofs_q[OFS_W-1:8]});
    pfr   = $signed({{(POS_W-8){1'b0}}, cfg_ofs_q[7:0]});
    pmx   = (pl >>> 1) + pfl;
    pmaxl = (cfg_ofs_q[7:0] == 8'd0) ? pmx - POS_W'(1) : pmx;
    pdl   = (pmx <<< 8) + pfr;
    pd0   = (pi <<< 1) + POS_W'(1) - pl;
    if (cfg_ofs_q == '0) begin
      pn = pd0[POS_W-1] ? -pd0 : pd0;
      pd = pl - POS_W'(1);
    end else if (pi <= pmaxl) begin
      pn = pdl - (pi <<< 8);
      pd = pdl;
    end else begin
      pn = ((pi - pmx) <<< 8) - pfr;
      pd = ((pl - pmx - POS_W'(1)) <<< 8) - pfr;
    end
  end

  // combinational arithmetic for the datapath operations
  logic [2*Q_W-1:0]        xsq;
  logic [Q_W-1:0]          u_c;
  logic [SQ_W-1:0]         sq_sum;
  logic [DIV_W-1:0]        div_rem2;
  logic [46:0]             hp;
  logic [68:0]             mp;
  logic [63:0]             tsq;
  logic [SUM_W-1:0]        wn;
  logic signed [55:0]      pm, pr, ps;
  logic signed [TAP_W-1:0] sat_c;
  logic [SER_W-1:0]        dq;
  logic [DIGIT_W:0]        rr, k9;
  logic [DIGIT_W-1:0]      dr;

  always_comb begin
    xsq      = (2*Q_W)'(div_val) * (2*Q_W)'(div_val);
    u_c      = ONE_Q30 - xsq[Q_W+29:30];
    sq_sum   = sq_res_q + SQ_W'(sq_bit_q);
    div_rem2 = {div_rem_q[DIV_W-2:0], 1'b0};
    hp       = 47'(beta_c) * 47'(sq_res_q[Q_W-1:0]);
    mp       = 69'(ser_a_q) * 69'(ser_half_q);
    tsq      = 64'(ser_a_q[46:15]) * 64'(ser_a_q[46:15]);
    wn       = (num_sum_q < den_sum_q) ? num_sum_q : den_sum_q;
    pm       = $signed({{32{tap_q[TAP_W-1]}}, tap_q}) * $signed({25'b0, div_val});
    pr       = pm + (56'sd1 <<< 29);
    ps       = pr >>> 30;
    if (ps > 56'sd8388607) begin
      sat_c = 24'sh7FFFFF;
    end else if (ps < -56'sd8388608) begin
      sat_c = -24'sh800000;
    end else begin
      sat_c = ps[TAP_W-1:0];
    end
    // one digit of the series divide by k
    dq = ser_a_q;
    dr = ser_r_q;
    k9 = (DIGIT_W+1)'(cmd_i.term);
    for (int j = 0; j < DIGIT_W; j++) begin
      rr = {dr, dq[SER_W-1]};
      dq = {dq[SER_W-2:0], 1'b0};
      if (rr >= k9) begin
        rr    = rr - k9;
        dq[0] = 1'b1;
      end
      dr = rr[DIGIT_W-1:0];
    end
  end

  // datapath operations
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        idx_q    <= item_i.tap_index;
        tap_q    <= item_i.tap_value;
        beyond_q <= (LEN_W'(item_i.tap_index) >= len_c);
      end
      OP_POS: begin
        div_q_q <= '0;
        if (pn <= 0 || pd <= 0) begin
          div_sat_q <= 1'b0;
          div_rem_q <= '0;
          div_d_q   <= DIV_W'(1);
        end else if (pn >= pd) begin
          div_sat_q <= 1'b1;
          div_rem_q <= '0;
          div_d_q   <= DIV_W'(1);
        end else begin
          div_sat_q <= 1'b0;
          div_rem_q <= DIV_W'(pn);
          div_d_q   <= DIV_W'(pd);
        end
      end
      OP_DIV: begin
        if (div_rem2 >= div_d_q) begin
          div_rem_q <= div_rem2 - div_d_q;
          div_q_q   <= {div_q_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          div_rem_q <= div_rem2;
          div_q_q   <= {div_q_q[DIV_STEPS-2:0], 1'b0};
        end
      end
      OP_X2: begin
        sq_v_q   <= {u_c, 30'b0};
        sq_res_q <= '0;
        sq_bit_q <= (SQ_W-1)'(1) << 60;
      end
      OP_SQRT: begin
        if (SQ_W'(sq_v_q) >= sq_sum) begin
          sq_v_q   <= sq_v_q - sq_sum[SQ_W-2:0];
          sq_res_q <= (sq_res_q >> 1) + SQ_W'(sq_bit_q);
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_HALF: half_num_q <= hp[46:26];
      OP_SER_INIT_DEN, OP_SER_INIT_NUM: begin
        ser_half_q <= (cmd_i.op == OP_SER_INIT_NUM) ? half_num_q
                                                    : HALF_W'({beta_c, 4'b0});
        ser_a_q    <= SER_W'(ONE_Q30);
        ser_sum_q  <= SUM_W'(ONE_Q30);
      end
      OP_SER_MUL: begin
        ser_a_q <= mp[SER_W+15:16];
        ser_r_q <= '0;
      end
      OP_SER_DIV: begin
        ser_a_q <= dq;
        ser_r_q <= dr;
      end
      OP_SER_ACC:      ser_sum_q <= ser_sum_q + tsq[SUM_W-1:0];
      OP_SER_SAVE_DEN: den_sum_q <= ser_sum_q;
      OP_SER_SAVE_NUM: num_sum_q <= ser_sum_q;
      OP_NORM: begin
        if (|den_sum_q[SUM_W-1:32]) begin
          den_sum_q <= den_sum_q >> 1;
          num_sum_q <= num_sum_q >> 1;
        end
      end
      OP_WINIT: begin
        div_q_q <= '0;
        div_d_q <= den_sum_q[DIV_W-1:0];
        if (wn >= den_sum_q) begin
          div_sat_q <= 1'b1;
          div_rem_q <= '0;
        end else begin
          div_sat_q <= 1'b0;
          div_rem_q <= wn[DIV_W-1:0];
        end
      end
      OP_PRODUCT: res_q <= sat_c;
      OP_OUT: begin
        result_q.shaped_tap    <= beyond_q ? tap_q : res_q;
        result_q.index_echo    <= idx_q;
        result_q.beyond_length <= beyond_q;
      end
      default: ;
    endcase
  end

  assign status_o.beyond = beyond_q;
  assign result_o        = result_q;

endmodule

// File: rtl/kaiser_window_tap_shaper.sv
// Kaiser window tap shaper: each request carries a tap index and a Q1.23
// coefficient and returns the coefficient times I0(beta*sqrt(1-x^2))/I0(beta),
// rounded and saturated, with the index echoed; an index at or past the window
// length passes the coefficient through with beyond_length set. One request is
// processed at a time: a request in the window runs the 30-step position
// division, the 31-step square root, the two Bessel series, each term one
// multiply, SER_W/8 divide-by-k digit steps and one square-accumulate, and
// the 30-step weight division; a request past the length goes from the check
// straight to the output. The next request is taken while a finished result
// still waits at the output. The user must write registers through the cfg
// port only while the block is idle; the block itself does not enforce this.
module kaiser_window_tap_shaper (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [kwts_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [kwts_pkg::CFG_W-1:0]  cfg_wdata_i,
  kwts_stream_if.sink                 in_if,
  kwts_stream_if.source               out_if
);
  import kwts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  out_item_t  result;
  in_item_t   item;

  assign item = in_item_t'(in_if.payload);

  // sequencer
  kwts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and registers
  kwts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

  assign out_if.payload = result;

endmodule
